// ----- src/fcou_pkg.sv -----
// Shared constants, command codes and the CORDIC arctangent table for the fly camera core.
`default_nettype none
package fcou_pkg;
  localparam int FRAC = 16;
  localparam int TAB_LEN = 28;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] CMD_FWD   = 3'd0;
  localparam logic [2:0] CMD_BACK  = 3'd1;
  localparam logic [2:0] CMD_LEFT  = 3'd2;
  localparam logic [2:0] CMD_RIGHT = 3'd3;
  localparam logic [2:0] CMD_LOOK  = 3'd4;

  localparam logic [2:0] REG_UP_X  = 3'd0;
  localparam logic [2:0] REG_UP_Y  = 3'd1;
  localparam logic [2:0] REG_UP_Z  = 3'd2;
  localparam logic [2:0] REG_SPEED = 3'd3;
  localparam logic [2:0] REG_SENS  = 3'd4;

  typedef logic signed [17:0] comp_t;

  function automatic logic signed [34:0] atan_deg(input logic [4:0] i);
    logic signed [34:0] r;
    case (i)
      5'd0:  r = 35'sd754974720;
      5'd1:  r = 35'sd445687602;
      5'd2:  r = 35'sd235489088;
      5'd3:  r = 35'sd119537938;
      5'd4:  r = 35'sd60000934;
      5'd5:  r = 35'sd30029717;
      5'd6:  r = 35'sd15018523;
      5'd7:  r = 35'sd7509720;
      5'd8:  r = 35'sd3754917;
      5'd9:  r = 35'sd1877466;
      5'd10: r = 35'sd938734;
      5'd11: r = 35'sd469367;
      5'd12: r = 35'sd234684;
      5'd13: r = 35'sd117342;
      5'd14: r = 35'sd58671;
      5'd15: r = 35'sd29335;
      5'd16: r = 35'sd14668;
      5'd17: r = 35'sd7334;
      5'd18: r = 35'sd3667;
      5'd19: r = 35'sd1833;
      5'd20: r = 35'sd917;
      5'd21: r = 35'sd458;
      5'd22: r = 35'sd229;
      5'd23: r = 35'sd115;
      5'd24: r = 35'sd57;
      5'd25: r = 35'sd29;
      5'd26: r = 35'sd14;
      5'd27: r = 35'sd7;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- src/fcou_mul.sv -----
// Shared signed 32 by 32 multiplier with registered product.
`default_nettype none
module fcou_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ----- src/fcou_cordic.sv -----
// Iterative rotation-mode CORDIC in degrees, one micro-rotation per cycle.
`default_nettype none
module fcou_cordic #(
  parameter int ITERS = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [33:0] ang,
  output logic                    done,
  output logic signed [31:0]      cos_out,
  output logic signed [31:0]      sin_out
);
  import fcou_pkg::*;

  localparam int N = (ITERS < TAB_LEN) ? ITERS : TAB_LEN;
  localparam int IW = $clog2(N + 1);
  localparam logic signed [34:0] HALF = 35'sd3019898880;
  localparam logic signed [34:0] QUARTER = 35'sd1509949440;

  logic                busy;
  logic [IW-1:0]       it;
  logic signed [33:0]  x;
  logic signed [33:0]  y;
  logic signed [34:0]  z;
  logic                neg;
  logic signed [34:0]  ang_w;
  logic signed [33:0]  xs;
  logic signed [33:0]  ys;
  logic signed [33:0]  xn;
  logic signed [33:0]  yn;

  always_comb begin
    ang_w = {ang[33], ang};
    xs = x >>> it;
    ys = y >>> it;
    xn = -x;
    yn = -y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        it <= '0;
        x <= CORDIC_GAIN;
        y <= '0;
        if (ang_w > QUARTER) begin
          z <= ang_w - HALF;
          neg <= 1'b1;
        end else if (ang_w < -QUARTER) begin
          z <= ang_w + HALF;
          neg <= 1'b1;
        end else begin
          z <= ang_w;
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (it == IW'(N)) begin
          busy <= 1'b0;
          done <= 1'b1;
          cos_out <= neg ? xn[31:0] : x[31:0];
          sin_out <= neg ? yn[31:0] : y[31:0];
        end else begin
          if (!z[34]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_deg(5'(it));
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_deg(5'(it));
          end
          it <= it + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/fcou_isqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module fcou_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [61:0] val,
  output logic             done,
  output logic [30:0]      root
);
  logic        busy;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] b;
  logic [63:0] rb;

  assign rb = r + b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v <= {2'b00, val};
        r <= '0;
        b <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (b == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= r[30:0];
        end else begin
          if (v >= rb) begin
            v <= v - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/fcou_div.sv -----
// Restoring divider, one quotient bit per cycle, 18 bit quotient.
`default_nettype none
module fcou_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [30:0] den,
  output logic             done,
  output logic [17:0]      quo
);
  logic        busy;
  logic [4:0]  cnt;
  logic [30:0] rem;
  logic [17:0] nsh;
  logic [17:0] q;
  logic [30:0] d;
  logic [31:0] t;

  assign t = {rem, nsh[17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= {1'b0, num[47:18]};
        nsh <= num[17:0];
        d <= den;
        q <= '0;
      end else if (busy) begin
        if (cnt == 5'd18) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo <= q;
        end else begin
          if (t >= {1'b0, d}) begin
            rem <= 31'(t - {1'b0, d});
            q <= {q[16:0], 1'b1};
          end else begin
            rem <= t[30:0];
            q <= {q[16:0], 1'b0};
          end
          nsh <= {nsh[16:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/fly_camera_orientation_update_core.sv -----
// Top level of the fly camera core: sequencer, camera state and result register.
`default_nettype none
// One beat in gives one beat out with the position and the front, right and up vectors.
// Beats are handled one at a time; in_stall stays high from acceptance until the result
// is loaded into the output register, which may still wait to be taken while the next
// beat is accepted. Moves use the shared multiplier once for the step and once per axis.
// A look runs eight yaw wrap steps, two CORDIC runs of TRIG_ITERATIONS (at most 28)
// rotations each, and two normalizations, each a normalizing shift, a 32-step square root
// and three 18-step divisions (a zero cross product gives a zero vector instead). Unused
// commands go straight to the result register. cfg_ready is always high; write
// configuration only while the core is idle.
module fly_camera_orientation_update_core #(
  parameter int TRIG_ITERATIONS = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         command,
  input  wire logic [19:0]        time_step,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [15:0] offset_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      position_x,
  output logic signed [31:0]      position_y,
  output logic signed [31:0]      position_z,
  output fcou_pkg::comp_t         front_x,
  output fcou_pkg::comp_t         front_y,
  output fcou_pkg::comp_t         front_z,
  output fcou_pkg::comp_t         right_x,
  output fcou_pkg::comp_t         right_y,
  output fcou_pkg::comp_t         right_z,
  output fcou_pkg::comp_t         up_x,
  output fcou_pkg::comp_t         up_y,
  output fcou_pkg::comp_t         up_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [21:0]        cfg_data
);
  import fcou_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MV_MUL, S_MV_STEP, S_MV_DIR, S_MV_ADD, S_LK_X, S_LK_Y, S_LK_P, S_WRAP,
    S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT, S_FX, S_FZ, S_FY, S_CROSS, S_NM_MAX,
    S_NM_SHIFT, S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT, S_FIN
  } state_t;

  localparam logic [34:0] PER = 35'd23592960;
  localparam logic signed [35:0] HALFP = 36'sd11796480;
  localparam logic signed [35:0] BIAS = 36'sd3019898880;
  localparam logic signed [33:0] LIM = 34'sd5832704;
  localparam logic signed [33:0] SMAX = 34'sd2147483647;
  localparam logic signed [33:0] SMIN = -34'sd2147483648;

  state_t             state;
  comp_t              wup [3];
  logic [21:0]        speed;
  logic [15:0]        sens;
  logic signed [31:0] loc [3];
  logic signed [25:0] yaw;
  logic signed [23:0] pitch;
  comp_t              fwd [3];
  comp_t              side [3];
  comp_t              top [3];
  logic [2:0]         cmd;
  logic [19:0]        dt;
  logic signed [15:0] ox;
  logic signed [15:0] oy;
  logic [26:0]        step;
  logic [1:0]         idx;
  logic [2:0]         cnt;
  logic [34:0]        wrap;
  logic [2:0]         k;
  logic signed [31:0] cy;
  logic signed [31:0] sy;
  logic signed [31:0] cp;
  logic signed [31:0] sp;
  logic signed [35:0] acc;
  logic signed [37:0] cv [3];
  logic [37:0]        mreg;
  logic [61:0]        sum;
  logic [30:0]        len;
  logic               pass;

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] p;
  logic               cor_start;
  logic signed [33:0] cor_ang;
  logic               cor_done;
  logic signed [31:0] cor_c;
  logic signed [31:0] cor_s;
  logic               sq_start;
  logic               sq_done;
  logic [30:0]        sq_root;
  logic               dv_start;
  logic [47:0]        dv_num;
  logic               dv_done;
  logic [17:0]        dv_quo;

  logic               use_side;
  logic               minus;
  comp_t              dir_c;
  comp_t              u_a;
  comp_t              v_b;
  logic [1:0]         comp;
  logic [1:0]         pcomp;
  logic signed [63:0] rnd16;
  logic signed [33:0] mv_d;
  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic [34:0]        per_k;
  logic [34:0]        wrap_sub;
  logic signed [35:0] yaw_sum;
  logic signed [33:0] pit_sum;
  logic signed [63:0] fr1;
  logic signed [63:0] fr2;
  logic signed [31:0] fy_w;
  logic [37:0]        mg [3];
  logic [37:0]        mmax;
  logic signed [37:0] cv_sel;
  logic [37:0]        cv_mag;
  logic signed [18:0] qs;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    use_side = (cmd == CMD_LEFT) || (cmd == CMD_RIGHT);
    minus = (cmd == CMD_BACK) || (cmd == CMD_LEFT);
    dir_c = use_side ? side[idx] : fwd[idx];
    comp = cnt[2:1];
    pcomp = 2'(({1'b0, cnt} - 4'd1) >> 1);
    u_a = '0;
    v_b = '0;
    unique case (comp)
      2'd0: begin
        u_a = pass ? (cnt[0] ? side[2] : side[1]) : (cnt[0] ? fwd[2] : fwd[1]);
        v_b = pass ? (cnt[0] ? fwd[1] : fwd[2]) : (cnt[0] ? wup[1] : wup[2]);
      end
      2'd1: begin
        u_a = pass ? (cnt[0] ? side[0] : side[2]) : (cnt[0] ? fwd[0] : fwd[2]);
        v_b = pass ? (cnt[0] ? fwd[2] : fwd[0]) : (cnt[0] ? wup[2] : wup[0]);
      end
      2'd2: begin
        u_a = pass ? (cnt[0] ? side[1] : side[0]) : (cnt[0] ? fwd[1] : fwd[0]);
        v_b = pass ? (cnt[0] ? fwd[0] : fwd[1]) : (cnt[0] ? wup[0] : wup[1]);
      end
      default: begin
        u_a = '0;
        v_b = '0;
      end
    endcase

    cv_sel = '0;
    case (state == S_SQ ? cnt[1:0] : idx)
      2'd0: cv_sel = cv[0];
      2'd1: cv_sel = cv[1];
      2'd2: cv_sel = cv[2];
      default: cv_sel = '0;
    endcase
    cv_mag = cv_sel[37] ? 38'(-cv_sel) : 38'(cv_sel);

    ma = '0;
    mb = '0;
    unique case (state)
      S_MV_MUL: begin
        ma = {10'b0, speed};
        mb = {12'b0, dt};
      end
      S_MV_DIR: begin
        ma = 32'(dir_c);
        mb = {5'b0, step};
      end
      S_LK_X: begin
        ma = 32'(ox);
        mb = {16'b0, sens};
      end
      S_LK_Y: begin
        ma = 32'(oy);
        mb = {16'b0, sens};
      end
      S_FX: begin
        ma = cy;
        mb = cp;
      end
      S_FZ: begin
        ma = sy;
        mb = cp;
      end
      S_CROSS: begin
        ma = 32'(u_a);
        mb = 32'(v_b);
      end
      S_SQ: begin
        ma = cv_sel[31:0];
        mb = cv_sel[31:0];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase

    rnd16 = (p + 64'sd32768) >>> 16;
    mv_d = minus ? -rnd16[33:0] : rnd16[33:0];
    mv_sum = 34'(loc[idx]) + mv_d;
    if (mv_sum > SMAX) mv_sat = SMAX[31:0];
    else if (mv_sum < SMIN) mv_sat = SMIN[31:0];
    else mv_sat = mv_sum[31:0];

    yaw_sum = 36'(yaw) + 36'($signed(p[31:0])) + HALFP + BIAS;
    pit_sum = 34'(pitch) + 34'($signed(p[31:0]));
    per_k = PER << k;
    wrap_sub = (wrap >= per_k) ? wrap - per_k : wrap;

    fr1 = (p + 64'sd536870912) >>> 30;
    fr2 = (fr1 + 64'sd8192) >>> 14;
    fy_w = (sp + 32'sd8192) >>> 14;

    for (int i = 0; i < 3; i++) begin
      mg[i] = cv[i][37] ? 38'(-cv[i]) : 38'(cv[i]);
    end
    mmax = mg[0];
    if (mg[1] > mmax) mmax = mg[1];
    if (mg[2] > mmax) mmax = mg[2];

    qs = cv_sel[37] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});

    cor_start = (state == S_CY_GO) || (state == S_CP_GO);
    cor_ang = (state == S_CY_GO) ? $signed({yaw, 8'b0}) : $signed({{2{pitch[23]}}, pitch, 8'b0});
    sq_start = (state == S_SQRT_GO);
    dv_start = (state == S_DIV_GO);
    dv_num = 48'({cv_mag[29:0], 16'b0}) + 48'(len >> 1);
  end

  fcou_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(p));

  fcou_cordic #(.ITERS(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .ang(cor_ang),
    .done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
  );

  fcou_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(sum), .done(sq_done), .root(sq_root)
  );

  fcou_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(len),
    .done(dv_done), .quo(dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      wup[0] <= '0;
      wup[1] <= 18'sd65536;
      wup[2] <= '0;
      speed <= 22'd163840;
      sens <= 16'd6554;
      loc[0] <= '0;
      loc[1] <= '0;
      loc[2] <= 32'sd196608;
      yaw <= -26'sd5898240;
      pitch <= '0;
      fwd[0] <= '0;
      fwd[1] <= '0;
      fwd[2] <= -18'sd65536;
      side[0] <= 18'sd65536;
      side[1] <= '0;
      side[2] <= '0;
      top[0] <= '0;
      top[1] <= 18'sd65536;
      top[2] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_UP_X:  wup[0] <= cfg_data[17:0];
          REG_UP_Y:  wup[1] <= cfg_data[17:0];
          REG_UP_Z:  wup[2] <= cfg_data[17:0];
          REG_SPEED: speed <= cfg_data;
          REG_SENS:  sens <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            dt <= time_step;
            ox <= offset_x;
            oy <= offset_y;
            case (command)
              CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT: state <= S_MV_MUL;
              CMD_LOOK: state <= S_LK_X;
              default: state <= S_FIN;
            endcase
          end
        end
        S_MV_MUL: state <= S_MV_STEP;
        S_MV_STEP: begin
          step <= rnd16[26:0];
          idx <= '0;
          state <= S_MV_DIR;
        end
        S_MV_DIR: state <= S_MV_ADD;
        S_MV_ADD: begin
          loc[idx] <= mv_sat;
          idx <= idx + 1'b1;
          state <= (idx == 2'd2) ? S_FIN : S_MV_DIR;
        end
        S_LK_X: state <= S_LK_Y;
        S_LK_Y: begin
          wrap <= yaw_sum[34:0];
          k <= 3'd7;
          state <= S_LK_P;
        end
        S_LK_P: begin
          if (pit_sum > LIM) pitch <= LIM[23:0];
          else if (pit_sum < -LIM) pitch <= 24'(-LIM);
          else pitch <= pit_sum[23:0];
          state <= S_WRAP;
        end
        S_WRAP: begin
          wrap <= wrap_sub;
          k <= k - 1'b1;
          if (k == 3'd0) begin
            yaw <= 26'($signed({1'b0, wrap_sub}) - HALFP);
            state <= S_CY_GO;
          end
        end
        S_CY_GO: state <= S_CY_WAIT;
        S_CY_WAIT: begin
          if (cor_done) begin
            cy <= cor_c;
            sy <= cor_s;
            state <= S_CP_GO;
          end
        end
        S_CP_GO: state <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (cor_done) begin
            cp <= cor_c;
            sp <= cor_s;
            state <= S_FX;
          end
        end
        S_FX: state <= S_FZ;
        S_FZ: begin
          fwd[0] <= fr2[17:0];
          state <= S_FY;
        end
        S_FY: begin
          fwd[2] <= fr2[17:0];
          fwd[1] <= fy_w[17:0];
          pass <= 1'b0;
          cnt <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          if (cnt != 3'd0) begin
            if (!cnt[0]) cv[pcomp] <= 38'(acc - $signed(p[35:0]));
            else acc <= p[35:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == 3'd6) state <= S_NM_MAX;
        end
        S_NM_MAX: begin
          mreg <= mmax;
          if (mmax == '0) begin
            for (int i = 0; i < 3; i++) begin
              if (pass) top[i] <= '0;
              else side[i] <= '0;
            end
            if (pass) begin
              state <= S_FIN;
            end else begin
              pass <= 1'b1;
              cnt <= '0;
              state <= S_CROSS;
            end
          end else begin
            state <= S_NM_SHIFT;
          end
        end
        S_NM_SHIFT: begin
          if (mreg >= 38'd1073741824) begin
            mreg <= mreg >> 1;
            for (int i = 0; i < 3; i++) cv[i] <= cv[i] >>> 1;
          end else if (mreg < 38'd536870912) begin
            mreg <= mreg << 1;
            for (int i = 0; i < 3; i++) cv[i] <= cv[i] <<< 1;
          end else begin
            cnt <= '0;
            sum <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt != 3'd0) sum <= sum + p[61:0];
          cnt <= cnt + 1'b1;
          if (cnt == 3'd3) state <= S_SQRT_GO;
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sq_done) begin
            len <= sq_root;
            idx <= '0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dv_done) begin
            if (pass) top[idx] <= qs[17:0];
            else side[idx] <= qs[17:0];
            idx <= idx + 1'b1;
            if (idx == 2'd2) begin
              if (pass) begin
                state <= S_FIN;
              end else begin
                pass <= 1'b1;
                cnt <= '0;
                state <= S_CROSS;
              end
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            position_x <= loc[0];
            position_y <= loc[1];
            position_z <= loc[2];
            front_x <= fwd[0];
            front_y <= fwd[1];
            front_z <= fwd[2];
            right_x <= side[0];
            right_y <= side[1];
            right_z <= side[2];
            up_x <= top[0];
            up_y <= top[1];
            up_z <= top[2];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("core ready right after accepting a beat");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_CY_WAIT || state == S_CP_WAIT))
    else $error("CORDIC result arrived outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == S_DIV_WAIT)
    else $error("divider result arrived outside its wait state");

  a_right_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_x <= 18'sd65536 && right_x >= -18'sd65536))
    else $error("right vector component out of unit range");
endmodule
`default_nettype wire

// ----- tb/sv/fly_camera_orientation_update_core_tb.sv -----
// Self-checking testbench for the fly camera orientation update core.
module fly_camera_orientation_update_core_tb;
  import fcou_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITER = 18;
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    longint pos [3];
    longint vec [9];
  } cam_view_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [19:0] dt;
    logic [15:0] ox;
    logic [15:0] oy;
    bit          known;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [19:0] time_step = '0;
  logic signed [15:0] offset_x = '0;
  logic signed [15:0] offset_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] position_x, position_y, position_z;
  comp_t front_x, front_y, front_z, right_x, right_y, right_z, up_x, up_y, up_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [21:0] cfg_data = '0;

  longint world_up [3];
  longint speed_q, sens_q;
  longint cam_pos [3];
  longint yaw_q, pitch_q;
  longint fwd [3], side [3], top [3];

  cam_view_t view_q [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off = 1'b0;
  cam_view_t reset_view;
  row_t rows [16];

  fly_camera_orientation_update_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit neg;
    neg = 0;
    if (ang > (64'sd90 <<< 24)) begin
      ang -= 64'sd180 <<< 24;
      neg = 1;
    end else if (ang < -(64'sd90 <<< 24)) begin
      ang += 64'sd180 <<< 24;
      neg = 1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = ang;
    for (int i = 0; i < NUM_ITER && i < TAB_LEN; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_deg(5'(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_deg(5'(i));
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic cross3(input longint u [3], input longint v [3], output longint r [3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endtask

  task automatic unit_vec(input longint in_v [3], output longint out_v [3]);
    longint m, len, q;
    longint unsigned sum;
    longint a [3];
    int s, t;
    m = 0;
    sum = 0;
    s = 0;
    t = 0;
    for (int i = 0; i < 3; i++) if (absval(in_v[i]) > m) m = absval(in_v[i]);
    if (m == 0) begin
      out_v = '{0, 0, 0};
      return;
    end
    while ((m >> s) >= (64'sd1 << 30)) s++;
    if (s == 0) while ((m << t) < (64'sd1 << 29)) t++;
    for (int i = 0; i < 3; i++) begin
      a[i] = s ? (in_v[i] >>> s) : (in_v[i] <<< t);
      sum += absval(a[i]) * absval(a[i]);
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        out_v[i] = 0;
      end else begin
        q = ((absval(a[i]) << FRAC) + len / 2) / len;
        out_v[i] = a[i] < 0 ? -q : q;
      end
    end
  endtask

  task automatic turn_camera(input longint dx, input longint dy);
    longint period, halfp, lim, v, cy, sy, cp, sp;
    longint f [3], tmp [3], r [3], u [3];
    period = 64'sd360 <<< FRAC;
    halfp = 64'sd180 <<< FRAC;
    lim = 64'sd89 <<< FRAC;
    v = (yaw_q + dx + halfp) % period;
    if (v < 0) v += period;
    yaw_q = v - halfp;
    v = pitch_q + dy;
    pitch_q = v > lim ? lim : (v < -lim ? -lim : v);
    sin_cos(yaw_q <<< (24 - FRAC), cy, sy);
    sin_cos(pitch_q <<< (24 - FRAC), cp, sp);
    f[0] = round_sh(round_sh(cy * cp, 30), 30 - FRAC);
    f[1] = round_sh(sp, 30 - FRAC);
    f[2] = round_sh(round_sh(sy * cp, 30), 30 - FRAC);
    cross3(f, world_up, tmp);
    unit_vec(tmp, r);
    cross3(r, f, tmp);
    unit_vec(tmp, u);
    fwd = f;
    side = r;
    top = u;
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic apply_command(input logic [2:0] cmd, input logic [19:0] dt,
                               input logic signed [15:0] ox, input logic signed [15:0] oy,
                               output cam_view_t res);
    longint step, d [3];
    if (cmd == CMD_FWD || cmd == CMD_BACK || cmd == CMD_LEFT || cmd == CMD_RIGHT) begin
      step = round_sh(speed_q * longint'(dt), FRAC);
      for (int i = 0; i < 3; i++) begin
        d[i] = round_sh(((cmd == CMD_LEFT || cmd == CMD_RIGHT) ? side[i] : fwd[i]) * step,
                        FRAC);
        if (cmd == CMD_BACK || cmd == CMD_LEFT) d[i] = -d[i];
        cam_pos[i] = clamp32(cam_pos[i] + d[i]);
      end
    end else if (cmd == CMD_LOOK) begin
      turn_camera(longint'(ox) * sens_q, longint'(oy) * sens_q);
    end
    res.pos = cam_pos;
    for (int i = 0; i < 3; i++) begin
      res.vec[i] = fwd[i];
      res.vec[3 + i] = side[i];
      res.vec[6 + i] = top[i];
    end
  endtask

  always @(posedge clk) begin
    cam_view_t want;
    longint got [12];
    longint exp_v;
    string names [12];
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        names = '{"position_x", "position_y", "position_z", "front_x", "front_y", "front_z",
                  "right_x", "right_y", "right_z", "up_x", "up_y", "up_z"};
        got = '{position_x, position_y, position_z, front_x, front_y, front_z,
                right_x, right_y, right_z, up_x, up_y, up_z};
        if (view_q.size() == 0) begin
          $display("%0t: unexpected result beat, position_x %0d", $time, position_x);
          fail_count++;
        end else begin
          want = view_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            exp_v = i < 3 ? longint'(signed'(32'(want.pos[i])))
                          : longint'(signed'(18'(want.vec[i - 3])));
            if (got[i] != exp_v) begin
              $display("%0t: %s expected %0d actual %0d", $time, names[i], exp_v, got[i]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  task automatic send_beat(input logic [2:0] cmd, input logic [19:0] dt,
                           input logic [15:0] ox, input logic [15:0] oy,
                           input bit known, input cam_view_t known_view);
    cam_view_t res;
    in_valid <= 1'b1;
    command <= cmd;
    time_step <= dt;
    offset_x <= ox;
    offset_y <= oy;
    do @(posedge clk); while (in_stall);
    apply_command(cmd, dt, ox, oy, res);
    view_q.push_back(known ? known_view : res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [21:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_UP_X:  world_up[0] = longint'(signed'(data[17:0]));
      REG_UP_Y:  world_up[1] = longint'(signed'(data[17:0]));
      REG_UP_Z:  world_up[2] = longint'(signed'(data[17:0]));
      REG_SPEED: speed_q = longint'(data);
      REG_SENS:  sens_q = longint'(data[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [21:0] ux, input logic [21:0] uy, input logic [21:0] uz,
                            input logic [21:0] spd, input logic [21:0] sns);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
    write_reg(REG_SPEED, spd);
    write_reg(REG_SENS, sns);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beats(input int n, input int look_pct, input bit push_fwd);
    logic [2:0] cmd;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < look_pct) cmd = CMD_LOOK;
      else if (pick < 92) cmd = push_fwd ? CMD_FWD : 3'($urandom_range(CMD_FWD, CMD_RIGHT));
      else cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
      send_beat(cmd, 20'($urandom), 16'($urandom), 16'($urandom), 0, reset_view);
    end
  endtask

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    world_up = '{0, 65536, 0};
    speed_q = 163840;
    sens_q = 6554;
    cam_pos = '{0, 0, 196608};
    yaw_q = -(64'sd90 <<< FRAC);
    pitch_q = 0;
    fwd = '{0, 0, -65536};
    side = '{65536, 0, 0};
    top = '{0, 65536, 0};
    reset_view.pos = '{0, 0, 196608};
    reset_view.vec = '{0, 0, -65536, 65536, 0, 0, 0, 65536, 0};
    rows = '{
      '{CMD_SPARE_5, 20'hFFFFF, 16'h7FFF, 16'h8000, 1},
      '{CMD_FWD,     20'h00000, 16'hFFFF, 16'hFFFF, 1},
      '{CMD_SPARE_7, 20'h00000, 16'h0000, 16'h0000, 1},
      '{CMD_FWD,     20'hFFFFF, 16'h0000, 16'h0000, 0},
      '{CMD_BACK,    20'h10000, 16'h0000, 16'h0000, 0},
      '{CMD_LEFT,    20'h08000, 16'h0000, 16'h0000, 0},
      '{CMD_RIGHT,   20'hFFFFF, 16'h1234, 16'h4321, 0},
      '{CMD_LOOK,    20'hFFFFF, 16'h0000, 16'h0000, 0},
      '{CMD_LOOK,    20'h00000, 16'h7FFF, 16'h0000, 0},
      '{CMD_LOOK,    20'h00000, 16'h8000, 16'h0000, 0},
      '{CMD_LOOK,    20'h00000, 16'h0000, 16'h7FFF, 0},
      '{CMD_FWD,     20'h10000, 16'h0000, 16'h0000, 0},
      '{CMD_LOOK,    20'h00000, 16'h0000, 16'h8000, 0},
      '{CMD_LOOK,    20'h00000, 16'h0708, 16'h0064, 0},
      '{CMD_SPARE_6, 20'h12345, 16'h5555, 16'hAAAA, 0},
      '{CMD_RIGHT,   20'h20000, 16'h0000, 16'h0000, 0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].dt, rows[i].ox, rows[i].oy, rows[i].known, reset_view);
    random_beats(130, 35, 0);
    wait_drained();

    set_config(22'h3F0000, 22'h0, 22'h0, 22'h3FFFFF, 22'hFFFF);
    send_idle_pct = 65;
    random_beats(60, 5, 1);
    random_beats(90, 30, 0);
    wait_drained();

    set_config(22'h0, 22'h0, 22'h0, 22'h0, 22'h0);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    random_beats(40, 40, 0);
    wait_drained();
    set_config(22'h0, 22'h3F0000, 22'h0, 22'h3FFFFF, 22'h0);
    random_beats(40, 40, 0);
    wait_drained();

    set_config(22'($urandom), 22'($urandom), 22'($urandom), 22'($urandom), 22'($urandom));
    send_idle_pct = 35;
    recv_stall_pct = 35;
    random_beats(140, 30, 0);
    wait_drained();

    set_config(22'h0, 22'h10000, 22'h0, 22'h28000, 22'h199A);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_beats(40, 20, 0);
    join
    wait_drained();
    set_config(22'h10000, 22'h10000, 22'h3F0000, 22'h1000, 22'h8000);
    random_beats(150, 30, 0);
    wait_drained();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
